// ===== rtl/qmm_pkg.sv =====
// Shared constants, codes and types of the quantized matrix multiply block.
`default_nettype none

package qmm_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int MAX_DEPTH = 256;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int DEPTH_W = $clog2(MAX_DEPTH);

    localparam int A_ADDR_W = ROW_W + DEPTH_W;
    localparam int B_ADDR_W = DEPTH_W + COL_W;
    localparam int C_ADDR_W = ROW_W + COL_W;

    localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
    localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
    localparam int C_DEPTH = MAX_ROWS * MAX_COLS;

    // Dimension register widths and the width of a row or column sum of bytes.
    localparam int DIM_W   = 4;
    localparam int K_W     = 9;
    localparam int SUM_W   = K_W + 8;
    localparam int WORD_W  = 32;
    localparam int MUL_Y_W = 9;

    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_LOAD_C  = 2'd2,
        ACT_COMPUTE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_ROWS_M   = 3'd0,
        REG_COLS_N   = 3'd1,
        REG_DEPTH_K  = 3'd2,
        REG_ALPHA    = 3'd3,
        REG_BETA     = 3'd4,
        REG_LHS_ZERO = 3'd5,
        REG_RHS_ZERO = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_SCALE,
        ST_PRIOR,
        ST_LHS,
        ST_RHS,
        ST_KPRE,
        ST_KADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  x;
        logic [MUL_Y_W-1:0] y;
        logic [WORD_W-1:0]  base;
        logic               sub;
    } mac_op_t;

    typedef struct packed {
        logic                a_we;
        logic                b_we;
        logic                c_we;
        logic [A_ADDR_W-1:0] a_addr;
        logic [B_ADDR_W-1:0] b_addr;
        logic [C_ADDR_W-1:0] c_addr;
        logic [7:0]          byte_val;
        logic [WORD_W-1:0]   word_val;
    } store_wr_t;

    typedef struct packed {
        logic [A_ADDR_W-1:0] a_addr;
        logic [B_ADDR_W-1:0] b_addr;
        logic [C_ADDR_W-1:0] c_addr;
    } store_rd_t;

endpackage

`default_nettype wire

// ===== rtl/qmm_mac.sv =====
// Shared multiply-accumulate unit: base plus or minus x times y, modulo 2^32.
`default_nettype none

module qmm_mac
    import qmm_pkg::*;
(
    input  mac_op_t           op,
    output logic [WORD_W-1:0] sum
);

    logic [WORD_W+MUL_Y_W-1:0] prod;

    assign prod = (WORD_W+MUL_Y_W)'(op.x) * (WORD_W+MUL_Y_W)'(op.y);

    always_comb
    begin
        if (op.sub)
        begin
            sum = op.base - prod[WORD_W-1:0];
        end
        else
        begin
            sum = op.base + prod[WORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qmm_store.sv =====
// Element stores for matrices A, B and C with registered read ports.
`default_nettype none

module qmm_store
    import qmm_pkg::*;
(
    input  logic              clk,
    input  store_wr_t         wr,
    input  store_rd_t         rd,
    output logic [7:0]        a_data,
    output logic [7:0]        b_data,
    output logic [WORD_W-1:0] c_data
);

    logic [7:0]        a_mem [0:A_DEPTH-1];
    logic [7:0]        b_mem [0:B_DEPTH-1];
    logic [WORD_W-1:0] c_mem [0:C_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr.a_we)
        begin
            a_mem[wr.a_addr] <= wr.byte_val;
        end
        a_data <= a_mem[rd.a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.b_we)
        begin
            b_mem[wr.b_addr] <= wr.byte_val;
        end
        b_data <= b_mem[rd.b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.c_we)
        begin
            c_mem[wr.c_addr] <= wr.word_val;
        end
        c_data <= c_mem[rd.c_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/quantized_matrix_multiply.sv =====
// Top level of the quantized matrix multiply block: sequencer, registers and output stage.
//
// Input items arrive on the s_axis channel; tuser carries the action. Load items for
// A, B and prior C are written straight into the stores and are taken one per cycle
// while the block is idle. A compute item is taken only while the block is idle; the
// block then walks the configured rows_m by cols_n C elements row by row and is not
// ready until the last element has been handed to the output register. For each
// element, in the ST_DOT product loop one shared multiply-accumulate unit consumes one
// A and one B byte per cycle from the single read port of each store; then, in the
// states ST_SCALE through ST_KADD, the same unit applies alpha, beta, both zero-point
// terms and the constant term, and ST_EMIT hands the element over.
// Results leave on the m_axis channel with tlast set on the final element. A single
// output register decouples the receiver; when it stalls, the sequencer waits on the
// pending element. Each result is also written back into the C store.
// Reset returns the registers to their defaults and empties the output register; the
// stores keep no reset state and must be loaded before use. Configuration writes are
// taken on any cycle with cfg_we high and are meant for an idle block.
`default_nettype none

module quantized_matrix_multiply
    import qmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_index[7:0], second_index[15:8], byte_value[23:16], prior_value[55:24]
    input  logic [55:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_row[2:0], out_col[5:3], result[37:6], zero fill[39:38]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [DIM_W-1:0] rows_m_reg;
    logic [DIM_W-1:0] cols_n_reg;
    logic [K_W-1:0]   depth_k_reg;
    logic [7:0]       alpha_reg;
    logic [7:0]       beta_reg;
    logic [7:0]       lhs_zero_reg;
    logic [7:0]       rhs_zero_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [ROW_W-1:0]  i_reg;
    logic [COL_W-1:0]  j_reg;
    logic [K_W-1:0]    l_reg;
    logic [DIM_W-1:0]  m_reg;
    logic [DIM_W-1:0]  n_reg;
    logic [K_W-1:0]    k_reg;
    logic              pend_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] tmp_reg;
    logic [SUM_W-1:0]  row_reg;
    logic [SUM_W-1:0]  col_reg;

    logic              out_valid_reg;
    logic [2:0]        out_row_reg;
    logic [2:0]        out_col_reg;
    logic [WORD_W-1:0] out_result_reg;
    logic              out_last_reg;

    logic [7:0]        in_first;
    logic [7:0]        in_second;
    logic [7:0]        in_byte;
    logic [WORD_W-1:0] in_prior;
    action_t           in_action;
    logic              in_fire;
    logic              start;

    logic [DIM_W-1:0]  m_clamp;
    logic [DIM_W-1:0]  n_clamp;
    logic [K_W-1:0]    k_clamp;

    logic              issue;
    logic              acc_en;
    logic              tmp_en;
    logic              emit_fire;
    logic              is_last;
    mac_op_t           mac_op;
    logic [WORD_W-1:0] mac_sum;
    store_wr_t         st_wr;
    store_rd_t         st_rd;
    logic [7:0]        a_data;
    logic [7:0]        b_data;
    logic [WORD_W-1:0] c_data;

    assign in_first  = s_axis_tdata[7:0];
    assign in_second = s_axis_tdata[15:8];
    assign in_byte   = s_axis_tdata[23:16];
    assign in_prior  = s_axis_tdata[55:24];
    assign in_action = action_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign start         = in_fire && (in_action == ACT_COMPUTE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_result_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        if (rows_m_reg == '0)
        begin
            m_clamp = DIM_W'(1);
        end
        else if (32'(rows_m_reg) > MAX_ROWS)
        begin
            m_clamp = DIM_W'(MAX_ROWS);
        end
        else
        begin
            m_clamp = rows_m_reg;
        end

        if (cols_n_reg == '0)
        begin
            n_clamp = DIM_W'(1);
        end
        else if (32'(cols_n_reg) > MAX_COLS)
        begin
            n_clamp = DIM_W'(MAX_COLS);
        end
        else
        begin
            n_clamp = cols_n_reg;
        end

        if (depth_k_reg == '0)
        begin
            k_clamp = K_W'(1);
        end
        else if (32'(depth_k_reg) > MAX_DEPTH)
        begin
            k_clamp = K_W'(MAX_DEPTH);
        end
        else
        begin
            k_clamp = depth_k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg   <= DIM_W'(8);
            cols_n_reg   <= DIM_W'(8);
            depth_k_reg  <= K_W'(256);
            alpha_reg    <= 8'd1;
            beta_reg     <= 8'd0;
            lhs_zero_reg <= 8'd0;
            rhs_zero_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ROWS_M:   rows_m_reg   <= cfg_data[DIM_W-1:0];
                REG_COLS_N:   cols_n_reg   <= cfg_data[DIM_W-1:0];
                REG_DEPTH_K:  depth_k_reg  <= cfg_data[K_W-1:0];
                REG_ALPHA:    alpha_reg    <= cfg_data[7:0];
                REG_BETA:     beta_reg     <= cfg_data[7:0];
                REG_LHS_ZERO: lhs_zero_reg <= cfg_data[7:0];
                REG_RHS_ZERO: rhs_zero_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    assign issue   = (state_reg == ST_DOT) && (l_reg < k_reg);
    assign is_last = ((DIM_W'(i_reg) + DIM_W'(1)) == m_reg)
                  && ((DIM_W'(j_reg) + DIM_W'(1)) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (!issue)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_PRIOR;
            ST_PRIOR: state_next = ST_LHS;
            ST_LHS:   state_next = ST_RHS;
            ST_RHS:   state_next = ST_KPRE;
            ST_KPRE:  state_next = ST_KADD;
            ST_KADD:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = is_last ? ST_IDLE : ST_DOT;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mac_op.x    = '0;
        mac_op.y    = '0;
        mac_op.base = acc_reg;
        mac_op.sub  = 1'b0;
        acc_en      = 1'b0;
        tmp_en      = 1'b0;
        emit_fire   = 1'b0;
        unique case (state_reg)
            ST_DOT:
            begin
                mac_op.x = WORD_W'(a_data);
                mac_op.y = MUL_Y_W'(b_data);
                acc_en   = pend_reg;
            end
            ST_SCALE:
            begin
                mac_op.x    = acc_reg;
                mac_op.y    = MUL_Y_W'(alpha_reg);
                mac_op.base = '0;
                acc_en      = 1'b1;
            end
            ST_PRIOR:
            begin
                mac_op.x = c_data;
                mac_op.y = MUL_Y_W'(beta_reg);
                acc_en   = (beta_reg != 8'd0);
            end
            ST_LHS:
            begin
                mac_op.x   = WORD_W'(col_reg);
                mac_op.y   = MUL_Y_W'(lhs_zero_reg);
                mac_op.sub = 1'b1;
                acc_en     = 1'b1;
            end
            ST_RHS:
            begin
                mac_op.x   = WORD_W'(row_reg);
                mac_op.y   = MUL_Y_W'(rhs_zero_reg);
                mac_op.sub = 1'b1;
                acc_en     = 1'b1;
            end
            ST_KPRE:
            begin
                mac_op.x    = WORD_W'(k_reg);
                mac_op.y    = MUL_Y_W'(rhs_zero_reg);
                mac_op.base = '0;
                tmp_en      = 1'b1;
            end
            ST_KADD:
            begin
                mac_op.x = tmp_reg;
                mac_op.y = MUL_Y_W'(lhs_zero_reg);
                acc_en   = 1'b1;
            end
            ST_EMIT:
            begin
                emit_fire = !out_valid_reg || m_axis_tready;
            end
            default:  ;
        endcase
    end

    always_comb
    begin
        st_rd.a_addr = {i_reg, DEPTH_W'(l_reg)};
        st_rd.b_addr = {DEPTH_W'(l_reg), j_reg};
        st_rd.c_addr = {i_reg, j_reg};

        st_wr.a_we     = in_fire && (in_action == ACT_LOAD_A)
                      && (32'(in_first) < MAX_ROWS) && (32'(in_second) < MAX_DEPTH);
        st_wr.b_we     = in_fire && (in_action == ACT_LOAD_B)
                      && (32'(in_first) < MAX_DEPTH) && (32'(in_second) < MAX_COLS);
        st_wr.a_addr   = {ROW_W'(in_first), DEPTH_W'(in_second)};
        st_wr.b_addr   = {DEPTH_W'(in_first), COL_W'(in_second)};
        st_wr.byte_val = in_byte;
        if (emit_fire)
        begin
            st_wr.c_we     = 1'b1;
            st_wr.c_addr   = {i_reg, j_reg};
            st_wr.word_val = acc_reg;
        end
        else
        begin
            st_wr.c_we     = in_fire && (in_action == ACT_LOAD_C)
                          && (32'(in_first) < MAX_ROWS) && (32'(in_second) < MAX_COLS);
            st_wr.c_addr   = {ROW_W'(in_first), COL_W'(in_second)};
            st_wr.word_val = in_prior;
        end
    end

    qmm_store u_store (
        .clk    (clk),
        .wr     (st_wr),
        .rd     (st_rd),
        .a_data (a_data),
        .b_data (b_data),
        .c_data (c_data)
    );

    qmm_mac u_mac (
        .op  (mac_op),
        .sum (mac_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            l_reg     <= '0;
            m_reg     <= DIM_W'(1);
            n_reg     <= DIM_W'(1);
            k_reg     <= K_W'(1);
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (start)
            begin
                i_reg <= '0;
                j_reg <= '0;
                l_reg <= '0;
                m_reg <= m_clamp;
                n_reg <= n_clamp;
                k_reg <= k_clamp;
            end
            else if (issue)
            begin
                l_reg <= l_reg + K_W'(1);
            end
            else if (emit_fire)
            begin
                l_reg <= '0;
                if ((DIM_W'(j_reg) + DIM_W'(1)) == n_reg)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + ROW_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start || emit_fire)
        begin
            acc_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            if (acc_en)
            begin
                acc_reg <= mac_sum;
            end
            if ((state_reg == ST_DOT) && pend_reg)
            begin
                row_reg <= row_reg + SUM_W'(a_data);
                col_reg <= col_reg + SUM_W'(b_data);
            end
        end
        if (tmp_en)
        begin
            tmp_reg <= mac_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_row_reg    <= 3'(i_reg);
            out_col_reg    <= 3'(j_reg);
            out_result_reg <= acc_reg;
            out_last_reg   <= is_last;
        end
    end

endmodule

`default_nettype wire
